/* rtl/pac_pkg.sv */
// Shared types and constants for the pedal auto-calibration percent block.
// No dependencies; used by pac_cal, pac_div and pedal_autocal_percent_core.
package pac_pkg;

  localparam int REG_W     = 12;  // width of the 12-bit configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CH_W      = 2;   // channel field width
  localparam int PCT_W     = 7;   // percent width, also quotient bits of the divider

  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_MIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_OFF_MODE = 2'd2;

  localparam logic [REG_W-1:0] DEAD_BAND_RST = 12'd0;
  localparam logic [REG_W-1:0] START_MIN_RST = 12'd4095;

  localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // what the calibration step decided for one beat
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,  // released or channel out of range
    KIND_FULL = 2'd1,  // pressed with motor off, or on/off mode
    KIND_DIV  = 2'd2   // pressed, percent from the divider
  } kind_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_stat_t;

endpackage

/* rtl/pac_cal.sv */
// Per-channel released/pressed level tracking and pressed/released decision.
// Depends on pac_pkg.
module pac_cal #(
  parameter int CH_N        = 3,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [pac_pkg::CH_W-1:0]   channel,
  input  logic [SAMPLE_BITS-1:0]     sample,
  input  logic                       motor_idle,
  input  logic [pac_pkg::REG_W-1:0]  dead_band,
  input  logic [pac_pkg::REG_W-1:0]  start_min,
  input  logic                       on_off_mode,
  output pac_pkg::kind_t             kind,
  output logic [SAMPLE_BITS-1:0]     n,
  output logic [SAMPLE_BITS-1:0]     d
);

  localparam int LW = (SAMPLE_BITS > pac_pkg::REG_W) ? SAMPLE_BITS : pac_pkg::REG_W;
  localparam int SW = LW + 1;

  logic [SAMPLE_BITS-1:0] released_level [CH_N];
  logic [LW-1:0]          pressed_level  [CH_N];

  logic [SAMPLE_BITS-1:0] rel_cur;
  logic [LW-1:0]          pl_cur;
  logic                   in_range;
  logic signed [SW-1:0]   start_pt;
  logic signed [SW-1:0]   smp_s;
  logic signed [SW-1:0]   lo_s;
  logic signed [SW-1:0]   n_full;
  logic signed [SW-1:0]   d_full;
  logic [LW-1:0]          lo;
  logic [LW-1:0]          smp_ext;
  logic                   pressed;
  logic                   rel_upd;

  always_comb begin
    rel_cur = '0;
    pl_cur  = '0;
    for (int i = 0; i < CH_N; i++) begin
      if (channel == pac_pkg::CH_W'(i)) begin
        rel_cur = released_level[i];
        pl_cur  = pressed_level[i];
      end
    end
  end

  assign in_range = int'(channel) < CH_N;
  assign smp_ext  = LW'(sample);
  assign start_pt = $signed({1'b0, LW'(rel_cur)}) - $signed({1'b0, LW'(dead_band)});
  assign smp_s    = $signed({1'b0, smp_ext});
  assign pressed  = in_range && (smp_s < start_pt);
  assign lo       = (smp_ext < pl_cur) ? smp_ext : pl_cur;
  assign lo_s     = $signed({1'b0, lo});
  // lo <= sample < start, so both are positive and fit the sample width
  assign n_full   = start_pt - smp_s;
  assign d_full   = start_pt - lo_s;
  assign rel_upd  = in_range && !pressed && ((sample > rel_cur) || !motor_idle);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH_N; i++) begin
        released_level[i] <= '0;
        pressed_level[i]  <= LW'(pac_pkg::START_MIN_RST);
      end
    end else if (en) begin
      for (int i = 0; i < CH_N; i++) begin
        if (channel == pac_pkg::CH_W'(i)) begin
          if (pressed) begin
            pressed_level[i] <= motor_idle ? LW'(start_min) : lo;
          end
          if (rel_upd) begin
            released_level[i] <= sample;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n <= n_full[SAMPLE_BITS-1:0];
      d <= d_full[SAMPLE_BITS-1:0];
      if (!pressed) begin
        kind <= pac_pkg::KIND_ZERO;
      end else if (motor_idle || on_off_mode) begin
        kind <= pac_pkg::KIND_FULL;
      end else begin
        kind <= pac_pkg::KIND_DIV;
      end
    end
  end

endmodule

/* rtl/pac_div.sv */
// Bit-serial restoring divider: (200*n + d) / (2*d), one quotient bit a cycle.
// Depends on pac_pkg.
module pac_div #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] n,
  input  logic [SAMPLE_BITS-1:0] d,
  output pac_pkg::div_stat_t     stat
);

  localparam int QB = pac_pkg::PCT_W;
  localparam int NW = SAMPLE_BITS + 8;  // 201*(2^SB-1) < 2^(SB+8)
  localparam int RW = SAMPLE_BITS + 1;
  localparam int CW = $clog2(QB);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_LOAD = 3'b010,
    D_RUN  = 3'b100
  } dstate_t;

  dstate_t         state;
  logic [NW-1:0]   num;
  logic [RW-1:0]   den;
  logic [RW-1:0]   rem;
  logic [QB-1:0]   num_lo;
  logic [QB-1:0]   quot;
  logic [CW-1:0]   cnt;
  logic            done;
  logic [RW:0]     trial;
  logic            ge;
  logic [RW-1:0]   diff;

  // quotient < 128, so the top bits of the numerator already sit below den
  assign trial = {rem, num_lo[QB-1]};
  assign ge    = trial >= {1'b0, den};
  // trial < 2*den, so the difference fits when ge is set
  assign diff  = trial[RW-1:0] - den;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= D_LOAD;
          end
        end
        D_LOAD: begin
          state <= D_RUN;
        end
        D_RUN: begin
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        num <= (NW'(n) << 7) + (NW'(n) << 6) + (NW'(n) << 3) + NW'(d);
        den <= {d, 1'b0};
      end
      D_LOAD: begin
        rem    <= num[NW-1:QB];
        num_lo <= num[QB-1:0];
        cnt    <= CW'(QB - 1);
      end
      D_RUN: begin
        rem    <= ge ? diff : trial[RW-1:0];
        num_lo <= num_lo << 1;
        quot   <= {quot[QB-2:0], ge};
        cnt    <= cnt - 1'b1;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

/* rtl/pedal_autocal_percent_core.sv */
// Pedal auto-calibration percent core: top level with stream ports and config port.
// Depends on pac_pkg, pac_cal and pac_div.

// One input beat carries an averaged ADC sample of one pedal channel and a
// motor-off flag; one output beat returns the channel and its depression in
// percent (0 released .. 100 fully pressed). Each channel self-calibrates: the
// released level follows every released sample while the motor runs and only a
// larger one while it is off, the pressed level the smallest pressed sample
// while the motor runs (reloaded from start_min while it is off), and the start
// point sits dead_band counts below the released level. The core handles one
// beat at a time. A beat whose result is 0 or 100 reaches the output register
// through level tracking, classify and hand over; a beat needing the division
// passes level tracking, classify with operand load, divider setup, the
// quotient-bit steps of the bit-serial restoring divider, quotient capture and
// hand over. The next input beat is accepted after the hand over, as soon as
// the previous result sits in the output register, even while the sink stalls.
// Configuration writes are always accepted (cfg_ready tied high) and must only
// be issued while the core is idle; a new start_min reaches a channel only at
// its next pressed beat with the motor off.
module pedal_autocal_percent_core #(
  parameter int CHANNELS    = 3,
  parameter int SAMPLE_BITS = 12,
  localparam int IN_W       = ((SAMPLE_BITS + 1 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [IN_W-1:0]                s_tdata,  // [SB-1:0] sample, [SB] motor_idle
  input  logic [pac_pkg::CH_W-1:0]       s_tuser,  // [1:0] channel
  // output stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [6:0] percent
  output logic [pac_pkg::CH_W-1:0]       m_tuser,  // [1:0] out_channel
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pac_pkg::REG_W-1:0]      cfg_data
);

  // the channel field is 2 bits wide, so at most four channels are reachable
  localparam int NCH = (CHANNELS < 4) ? CHANNELS : 4;

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_CAL  = 5'b00010,
    T_KIND = 5'b00100,
    T_DIV  = 5'b01000,
    T_OUT  = 5'b10000
  } tstate_t;

  tstate_t                       state;
  logic [pac_pkg::REG_W-1:0]     dead_band;
  logic [pac_pkg::REG_W-1:0]     start_min;
  logic                          on_off_mode;

  // latched input beat
  logic [pac_pkg::CH_W-1:0]      channel;
  logic [SAMPLE_BITS-1:0]        sample;
  logic                          motor_idle;

  pac_pkg::kind_t                cal_kind;
  logic [SAMPLE_BITS-1:0]        cal_n;
  logic [SAMPLE_BITS-1:0]        cal_d;
  pac_pkg::div_stat_t            div_stat;
  logic                          div_start;
  logic [pac_pkg::PCT_W-1:0]     percent;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == T_IDLE);
  assign div_start = (state == T_KIND) && (cal_kind == pac_pkg::KIND_DIV);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= pac_pkg::DEAD_BAND_RST;
      start_min   <= pac_pkg::START_MIN_RST;
      on_off_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pac_pkg::REG_DEAD_BAND:   dead_band   <= cfg_data;
        pac_pkg::REG_START_MIN:   start_min   <= cfg_data;
        pac_pkg::REG_ON_OFF_MODE: on_off_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // level tracking, enabled in T_CAL
  pac_cal #(
    .CH_N        (NCH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cal (
    .clk         (clk),
    .rst         (rst),
    .en          (state == T_CAL),
    .channel     (channel),
    .sample      (sample),
    .motor_idle  (motor_idle),
    .dead_band   (dead_band),
    .start_min   (start_min),
    .on_off_mode (on_off_mode),
    .kind        (cal_kind),
    .n           (cal_n),
    .d           (cal_d)
  );

  // rounded percent = floor((200n + d) / 2d)
  pac_div #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (cal_n),
    .d     (cal_d),
    .stat  (div_stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      case (state)
        T_IDLE: begin
          if (s_tvalid && s_tready) begin
            state <= T_CAL;
          end
        end
        T_CAL: begin
          state <= T_KIND;
        end
        T_KIND: begin
          state <= (cal_kind == pac_pkg::KIND_DIV) ? T_DIV : T_OUT;
        end
        T_DIV: begin
          if (div_stat.done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          // hand over once the output register is free or draining
          if (!m_tvalid || m_tready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // beat and result payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      channel    <= s_tuser;
      sample     <= s_tdata[SAMPLE_BITS-1:0];
      motor_idle <= s_tdata[SAMPLE_BITS];
    end
    if (state == T_KIND) begin
      percent <= (cal_kind == pac_pkg::KIND_FULL) ? pac_pkg::PCT_FULL : pac_pkg::PCT_ZERO;
    end else if (state == T_DIV && div_stat.done) begin
      percent <= div_stat.quot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == T_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, percent};
      m_tuser <= channel;
    end
  end

`ifndef NO_ASSERTIONS
  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == T_DIV)
    else $error("divider done outside T_DIV");

  // a divide request always has a positive divisor and n <= d
  a_div_operands: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (cal_d != '0 && cal_n <= cal_d))
    else $error("bad divider operands");

  // results never exceed full scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[6:0] <= pac_pkg::PCT_FULL)
    else $error("percent above 100");

  // a pending result is never overwritten by the next one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output overwritten while stalled");
`endif

endmodule

/* sim/pedal_autocal_percent_core_test.sv */
// Self-checking testbench for pedal_autocal_percent_core: directed and random pedal beats,
// predicted by a scoreboard class that tracks the per-channel calibration levels.
// Depends on pac_pkg and the core RTL only.
module pedal_autocal_percent_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH_W        = pac_pkg::CH_W;
  localparam int PCT_W       = pac_pkg::PCT_W;
  localparam int REG_W       = pac_pkg::REG_W;
  localparam int CFG_IDX_W   = pac_pkg::CFG_IDX_W;
  localparam int CHANNELS    = 3;
  localparam int SAMPLE_BITS = 12;
  localparam int IN_W        = ((SAMPLE_BITS + 1 + 7) / 8) * 8;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  // leave margin after the last expected beat
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;   // long sink stall used to back up the core
  // cycles with no beat on any channel before giving up; covers the long sink
  // stall plus rare long runs of random idling on either side
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 200;
  localparam int PHASES        = 6;

  // one expected output beat
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [PCT_W-1:0] pct;
  } pedal_pct_t;

  // Tracks calibration state and register values, predicts the percent of each
  // accepted beat and compares output beats in order.
  class pedal_scoreboard;
    logic [REG_W-1:0]       dead_band;
    logic [REG_W-1:0]       start_min;
    logic                   on_off;
    logic [SAMPLE_BITS-1:0] released [CHANNELS];
    logic [SAMPLE_BITS-1:0] pressed  [CHANNELS];
    pedal_pct_t             pct_q[$];
    int                     errors;

    function new();
      dead_band = pac_pkg::DEAD_BAND_RST;
      start_min = pac_pkg::START_MIN_RST;
      on_off    = 1'b0;
      errors    = 0;
      foreach (released[i]) begin
        released[i] = '0;
        pressed[i]  = pac_pkg::START_MIN_RST;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        pac_pkg::REG_DEAD_BAND:   dead_band = val;
        pac_pkg::REG_START_MIN:   start_min = val;
        pac_pkg::REG_ON_OFF_MODE: on_off    = val[0];
        default: ;
      endcase
    endfunction

    // input beat accepted: update channel levels and queue its percent
    function void note_input(logic [CH_W-1:0] ch, logic [SAMPLE_BITS-1:0] smp,
                             logic moff);
      int         start;
      int         d;
      int         n;
      int         q;
      pedal_pct_t res;
      res.ch  = ch;
      res.pct = pac_pkg::PCT_ZERO;
      if (ch < CHANNELS) begin
        // start point may go negative when dead band exceeds released level
        start = int'(released[ch]) - int'(dead_band);
        if (int'(smp) < start) begin
          if (moff) begin
            pressed[ch] = start_min;
            res.pct     = pac_pkg::PCT_FULL;
          end else begin
            if (smp < pressed[ch]) pressed[ch] = smp;
            d = start - int'(pressed[ch]);
            n = start - int'(smp);
            // half-up rounding of 100*n/d in integers
            if (d <= 0) q = 100;
            else q = (200 * n + d) / (2 * d);
            if (q > 100) q = 100;
            if (q < 0) q = 0;
            res.pct = on_off ? pac_pkg::PCT_FULL : PCT_W'(q);
          end
        end else if (smp > released[ch] || !moff) begin
          released[ch] = smp;
        end
      end
      pct_q.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CH_W-1:0] ch, logic [PCT_W-1:0] pct);
      pedal_pct_t exp_b;
      if (pct_q.size() == 0) begin
        report($sformatf("unexpected beat ch %0d pct %0d", ch, pct));
        return;
      end
      exp_b = pct_q.pop_front();
      if (ch !== exp_b.ch)
        report($sformatf("channel %0d, expected %0d", ch, exp_b.ch));
      if (pct !== exp_b.pct)
        report($sformatf("ch %0d percent %0d, expected %0d", exp_b.ch, pct, exp_b.pct));
    endtask

    function int pending();
      return pct_q.size();
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata   = '0;   // [11:0] sample, [12] motor_idle
  logic [CH_W-1:0]      s_tuser   = '0;   // [1:0] channel
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;          // [6:0] percent
  logic [CH_W-1:0]      m_tuser;          // [1:0] out_channel
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data  = '0;

  pedal_scoreboard sb;
  int   send_idle = 0;     // percent of cycles the source idles after a beat
  int   recv_idle = 0;     // percent of cycles the sink drops tready
  logic rx_hold   = 1'b0;  // forces a long sink stall
  int   quiet     = 0;     // cycles since the last beat on any channel
  event rx_hold_req;

  pedal_autocal_percent_core #(
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Sink: checks every accepted output beat, then picks tready for the next
  // cycle. rx_hold keeps tready low for a long stretch.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[PCT_W-1:0]);
    m_tready <= !rx_hold && ($urandom_range(99, 0) >= recv_idle);
  end

  // Long sink stall, counted here while the source keeps offering beats.
  initial forever begin
    @(rx_hold_req);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog on lack of progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one beat and hold it until accepted. tvalid drops only when an idle
  // gap follows, so back-to-back beats never see a low/high pair in one step.
  task automatic send_beat(input logic [CH_W-1:0] ch, input logic [SAMPLE_BITS-1:0] smp,
                           input logic moff);
    s_tvalid <= 1'b1;
    s_tdata  <= IN_W'({moff, smp});
    s_tuser  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(ch, smp, moff);
    if ($urandom_range(99, 0) < send_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle);
    end
  endtask

  // Stop the source, wait for every expected beat, then let the pipeline go quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers while the core is idle.
  task automatic set_config(input logic [REG_W-1:0] db, input logic [REG_W-1:0] sm,
                            input logic oo);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [REG_W-1:0]     val [3];
    idx[0] = pac_pkg::REG_DEAD_BAND;
    idx[1] = pac_pkg::REG_START_MIN;
    idx[2] = pac_pkg::REG_ON_OFF_MODE;
    val[0] = db;
    val[1] = sm;
    val[2] = REG_W'(oo);
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly press cycles on a real channel: a released sample sets the level,
  // then a run of pressed samples below the start point, sometimes with the
  // motor off, sometimes a motor-off sample inside the dead band. The rest is
  // noise over the full field ranges, out-of-range channel included.
  task automatic run_random(input int items, input bit with_hold);
    int sent;
    int ch;
    int rel;
    int db;
    int presses;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < items) begin
      if (with_hold && !held && sent >= items / 2) begin
        -> rx_hold_req;
        held = 1'b1;
      end
      if ($urandom_range(99, 0) < 20) begin
        send_beat(CH_W'($urandom_range(3, 0)), SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0)),
                  1'($urandom_range(1, 0)));
        sent++;
      end else begin
        db  = int'(sb.dead_band);
        ch  = $urandom_range(CHANNELS - 1, 0);
        rel = $urandom_range(SAMPLE_MAX, 600);
        send_beat(CH_W'(ch), SAMPLE_BITS'(rel), 1'b0);
        sent++;
        presses = $urandom_range(8, 1);
        for (int j = 0; j < presses; j++) begin
          if (rel > db)
            send_beat(CH_W'(ch), SAMPLE_BITS'($urandom_range(rel - db - 1, 0)),
                      $urandom_range(9, 0) == 0);
          else
            send_beat(CH_W'(ch), SAMPLE_BITS'($urandom_range(SAMPLE_MAX, 0)),
                      $urandom_range(9, 0) == 0);
          sent++;
        end
        if ($urandom_range(1, 0)) begin
          // released with motor off, not above the released level
          send_beat(CH_W'(ch), SAMPLE_BITS'(rel - int'($urandom_range(db < rel ? db : rel, 0))),
                    1'b1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, reset configuration, no idling
    send_beat(2'd0, 12'd0,    1'b0);  // sample equal to start point: released
    send_beat(2'd0, 12'd4095, 1'b1);  // motor off may still raise released level
    send_beat(2'd0, 12'd0,    1'b0);  // full travel
    send_beat(2'd0, 12'd2048, 1'b0);  // mid travel
    send_beat(2'd0, 12'd4094, 1'b0);  // one count pressed rounds to zero
    send_beat(2'd0, 12'd100,  1'b1);  // pressed with motor off reloads pressed level
    send_beat(2'd0, 12'd4000, 1'b0);
    send_beat(2'd0, 12'd4095, 1'b0);
    send_beat(2'd2, 12'd200,  1'b0);
    send_beat(2'd2, 12'd0,    1'b0);
    send_beat(2'd2, 12'd199,  1'b0);  // exactly half a percent rounds up
    send_beat(2'd2, 12'd101,  1'b0);
    send_beat(2'd2, 12'd1,    1'b0);
    send_beat(2'd3, 12'd4095, 1'b1);  // channel out of range
    send_beat(2'd3, 12'd0,    1'b0);
    send_beat(2'd1, 12'd4095, 1'b0);
    send_beat(2'd1, 12'd4094, 1'b0);  // span of a single count
    // dead band equal to released level: start point at zero
    set_config(12'd4095, 12'd0, 1'b1);
    send_beat(2'd1, 12'd0,    1'b1);
    send_beat(2'd1, 12'd4095, 1'b1);
    set_config(12'd1, 12'd0, 1'b1);
    send_beat(2'd1, 12'd4093, 1'b0);  // on/off mode forces full
    send_beat(2'd1, 12'd4094, 1'b1);  // inside dead band, motor off: level kept
    send_beat(2'd1, 12'd3000, 1'b1);  // pressed level reloads from new start_min

    // random phases: configuration and idling pattern change per phase
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(pac_pkg::DEAD_BAND_RST, pac_pkg::START_MIN_RST, 1'b0);
        1: set_config(12'd4095, 12'd0, 1'b1);
        2: set_config(REG_W'($urandom_range(200, 1)), REG_W'($urandom_range(SAMPLE_MAX, 0)),
                      1'b0);
        3: set_config(REG_W'($urandom_range(1500, 0)), REG_W'($urandom_range(SAMPLE_MAX, 0)),
                      1'b1);
        4: set_config(REG_W'($urandom_range(50, 0)), pac_pkg::START_MIN_RST, 1'b0);
        default: set_config(REG_W'($urandom_range(SAMPLE_MAX, 0)),
                            REG_W'($urandom_range(SAMPLE_MAX, 0)), 1'b0);
      endcase
      case (p % 3)
        0: begin
          send_idle = 35;
          recv_idle = 85;
        end
        1: begin
          send_idle = 85;
          recv_idle = 35;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      run_random(PHASE_ITEMS, p == 2);
    end

    settle();
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
rtl/pac_pkg.sv
rtl/pac_cal.sv
rtl/pac_div.sv
rtl/pedal_autocal_percent_core.sv
sim/pedal_autocal_percent_core_test.sv
